FILE: hw/rtl/datetime_string_parse_validate_unit_assert.svh
// Assertion macros shared by the date-time parser RTL.
// Defining NO_ASSERTIONS removes every check from the build.
`ifndef DATETIME_STRING_PARSE_VALIDATE_UNIT_ASSERT_SVH
`define DATETIME_STRING_PARSE_VALIDATE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DTP_ASSERT_NOW(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("Same-cycle check failed.");
`define DTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");
`else
`define DTP_ASSERT_NOW(lbl, clk, rst_n, prop)
`define DTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/dtp_pkg.sv
// Shared types and constants of the date-time string parser.
// Used by dtp_front, dtp_queue, dtp_check and the top level; no dependencies.
package dtp_pkg;

    localparam int YEAR_W   = 14;
    localparam int ACC_W    = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int POS_W    = 5;

    localparam int OUT_DATA_W = 40;
    localparam int IN_DATA_W  = 8;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [POS_W-1:0] POS_HI_END  = 5'd2;
    localparam logic [POS_W-1:0] POS_DASH_A  = 5'd4;
    localparam logic [POS_W-1:0] POS_DASH_B  = 5'd7;
    localparam logic [POS_W-1:0] POS_SLASH   = 5'd10;
    localparam logic [POS_W-1:0] POS_COLON   = 5'd13;
    localparam logic [POS_W-1:0] STR_LEN     = 5'd16;
    localparam logic [POS_W-1:0] POS_SAT     = 5'd17;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1000;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [ACC_W-1:0]  MONTH_MAX  = 7'd12;
    localparam logic [ACC_W-1:0]  MONTH_FEB  = 7'd2;
    localparam logic [ACC_W-1:0]  MONTH_AUG  = 7'd8;
    localparam logic [ACC_W-1:0]  HOUR_MAX   = 7'd23;
    localparam logic [ACC_W-1:0]  MINUTE_MAX = 7'd59;
    localparam logic [ACC_W-1:0]  DAYS_28    = 7'd28;
    localparam logic [ACC_W-1:0]  DAYS_29    = 7'd29;
    localparam logic [ACC_W-1:0]  DAYS_30    = 7'd30;
    localparam logic [ACC_W-1:0]  DAYS_31    = 7'd31;

    typedef struct packed {
        logic              fmt_ok;
        logic              leap;
        logic [YEAR_W-1:0] year;
        logic [ACC_W-1:0]  month;
        logic [ACC_W-1:0]  day;
        logic [ACC_W-1:0]  hour;
        logic [ACC_W-1:0]  minute;
    } dtp_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dtp_qstat_t;

endpackage

FILE: hw/rtl/datetime_string_parse_validate_unit.sv
// Top level of the date-time string parser: front end, record queue, calendar check.
// Depends on dtp_pkg, dtp_front, dtp_queue and dtp_check.
//
//   Channel  | Direction | Beat                    | Content
//   s_axis   | in        | one string character    | tdata[7:0] char, tlast end of string
//   m_axis   | out       | one result per string   | tdata fields, tuser valid flag
//
// Character beats are taken at one beat per cycle when the queue has room.
// A finished result passes through a queue entry and then the output register before it leaves.
// The two-entry queue and output register let characters flow while a result waits.
// Reset clears the position counter, accumulators, queue pointers and output valid.
module datetime_string_parse_validate_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dtp_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [7:0] char_code
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // year_out, month_out, day_out, hour_out, minute_out, zeros
    output logic [dtp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tuser    // valid_res
);

    dtp_pkg::dtp_rec_t   front_rec;
    dtp_pkg::dtp_rec_t   queue_rec;
    dtp_pkg::dtp_qstat_t qstat;
    logic                rec_push;
    logic                rec_pop;
    logic                char_valid;
    logic [dtp_pkg::YEAR_W-1:0]   year_out;
    logic [dtp_pkg::MONTH_W-1:0]  month_out;
    logic [dtp_pkg::DAY_W-1:0]    day_out;
    logic [dtp_pkg::HOUR_W-1:0]   hour_out;
    logic [dtp_pkg::MINUTE_W-1:0] minute_out;

    assign s_axis_tready = !qstat.full;
    assign char_valid    = s_axis_tvalid && s_axis_tready;

    dtp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .char_valid (char_valid),
        .char_code  (s_axis_tdata),
        .is_last    (s_axis_tlast),
        .rec        (front_rec),
        .rec_push   (rec_push)
    );

    dtp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (rec_push),
        .push_rec (front_rec),
        .pop      (rec_pop),
        .pop_rec  (queue_rec),
        .stat     (qstat)
    );

    dtp_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rec        (queue_rec),
        .stat       (qstat),
        .pop        (rec_pop),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .valid_res  (m_axis_tuser),
        .year_out   (year_out),
        .month_out  (month_out),
        .day_out    (day_out),
        .hour_out   (hour_out),
        .minute_out (minute_out)
    );

    assign m_axis_tdata = {6'd0, minute_out, hour_out, day_out, month_out, year_out};

endmodule

FILE: hw/rtl/dtp_front.sv
// Character front end: checks each byte of the string and accumulates the fields.
// Emits one record per string into the queue. Depends on dtp_pkg.
module dtp_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             char_valid,
    input  logic [7:0]       char_code,
    input  logic             is_last,
    output dtp_pkg::dtp_rec_t rec,
    output logic             rec_push
);

    logic [dtp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                       fmt_reg, fmt_next;
    logic [dtp_pkg::YEAR_W-1:0] year_reg, year_next;
    logic [dtp_pkg::ACC_W-1:0]  month_reg, month_next;
    logic [dtp_pkg::ACC_W-1:0]  day_reg, day_next;
    logic [dtp_pkg::ACC_W-1:0]  hour_reg, hour_next;
    logic [dtp_pkg::ACC_W-1:0]  minute_reg, minute_next;
    logic [dtp_pkg::ACC_W-1:0]  yhi_reg, yhi_next;
    logic [dtp_pkg::ACC_W-1:0]  ylo_reg, ylo_next;
    logic                       is_digit;
    logic [3:0]                 digit;

    function automatic logic [dtp_pkg::ACC_W-1:0] acc7(
        input logic [dtp_pkg::ACC_W-1:0] acc,
        input logic [3:0]                d
    );
        acc7 = {acc[3:0], 3'b000} + {acc[5:0], 1'b0} + {3'b000, d};
    endfunction

    assign is_digit = (char_code >= dtp_pkg::CH_ZERO) && (char_code <= dtp_pkg::CH_NINE);
    assign digit    = is_digit ? char_code[3:0] : 4'd0;

    always_comb begin
        fmt_next    = fmt_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        yhi_next    = yhi_reg;
        ylo_next    = ylo_reg;

        if (pos_reg >= dtp_pkg::STR_LEN) begin
            fmt_next = 1'b0;
        end else if (pos_reg == dtp_pkg::POS_DASH_A || pos_reg == dtp_pkg::POS_DASH_B) begin
            if (char_code != dtp_pkg::CH_DASH) begin
                fmt_next = 1'b0;
            end
        end else if (pos_reg == dtp_pkg::POS_SLASH) begin
            if (char_code != dtp_pkg::CH_SLASH) begin
                fmt_next = 1'b0;
            end
        end else if (pos_reg == dtp_pkg::POS_COLON) begin
            if (char_code != dtp_pkg::CH_COLON) begin
                fmt_next = 1'b0;
            end
        end else if (!is_digit) begin
            fmt_next = 1'b0;
        end else if (pos_reg < dtp_pkg::POS_DASH_A) begin
            year_next = {year_reg[10:0], 3'b000} + {year_reg[12:0], 1'b0}
                        + {10'd0, digit};
            if (pos_reg < dtp_pkg::POS_HI_END) begin
                yhi_next = acc7(yhi_reg, digit);
            end else begin
                ylo_next = acc7(ylo_reg, digit);
            end
        end else if (pos_reg < dtp_pkg::POS_DASH_B) begin
            month_next = acc7(month_reg, digit);
        end else if (pos_reg < dtp_pkg::POS_SLASH) begin
            day_next = acc7(day_reg, digit);
        end else if (pos_reg < dtp_pkg::POS_COLON) begin
            hour_next = acc7(hour_reg, digit);
        end else begin
            minute_next = acc7(minute_reg, digit);
        end

        pos_next = (pos_reg < dtp_pkg::POS_SAT) ? pos_reg + 5'd1 : dtp_pkg::POS_SAT;
    end

    // A year is a leap year when its last two digits are a nonzero multiple of
    // four, or when they are zero and the century digits are a multiple of four.
    always_comb begin
        rec.fmt_ok = fmt_next && (pos_next == dtp_pkg::STR_LEN);
        rec.leap   = (ylo_next != '0) ? (ylo_next[1:0] == 2'b00) : (yhi_next[1:0] == 2'b00);
        rec.year   = year_next;
        rec.month  = month_next;
        rec.day    = day_next;
        rec.hour   = hour_next;
        rec.minute = minute_next;
    end

    assign rec_push = char_valid && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn || rec_push) begin
            pos_reg    <= '0;
            fmt_reg    <= 1'b1;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            yhi_reg    <= '0;
            ylo_reg    <= '0;
        end else if (char_valid) begin
            pos_reg    <= pos_next;
            fmt_reg    <= fmt_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            yhi_reg    <= yhi_next;
            ylo_reg    <= ylo_next;
        end
    end

endmodule

FILE: hw/rtl/dtp_queue.sv
// Short record queue between the character front end and the calendar check.
// Depends on dtp_pkg for the record type and depth.
module dtp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  dtp_pkg::dtp_rec_t  push_rec,
    input  logic               pop,
    output dtp_pkg::dtp_rec_t  pop_rec,
    output dtp_pkg::dtp_qstat_t stat
);

    dtp_pkg::dtp_rec_t          entry_reg [dtp_pkg::QDEPTH];
    logic [dtp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dtp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dtp_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_push, do_pop;

    assign stat.full  = (count_reg == dtp_pkg::QCNT_W'(dtp_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_rec    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == dtp_pkg::QPTR_W'(dtp_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == dtp_pkg::QPTR_W'(dtp_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + dtp_pkg::QCNT_W'(do_push) - dtp_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

FILE: hw/rtl/dtp_check.sv
// Calendar range check and output register of the date-time parser.
// Depends on dtp_pkg and the assertion macro header.
`include "datetime_string_parse_validate_unit_assert.svh"

module dtp_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  dtp_pkg::dtp_rec_t   rec,
    input  dtp_pkg::dtp_qstat_t stat,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                valid_res,
    output logic [dtp_pkg::YEAR_W-1:0]   year_out,
    output logic [dtp_pkg::MONTH_W-1:0]  month_out,
    output logic [dtp_pkg::DAY_W-1:0]    day_out,
    output logic [dtp_pkg::HOUR_W-1:0]   hour_out,
    output logic [dtp_pkg::MINUTE_W-1:0] minute_out
);

    logic                          m_valid_reg, m_valid_next;
    logic                          res_ok_reg;
    logic [dtp_pkg::YEAR_W-1:0]    year_reg;
    logic [dtp_pkg::MONTH_W-1:0]   month_reg;
    logic [dtp_pkg::DAY_W-1:0]     day_reg;
    logic [dtp_pkg::HOUR_W-1:0]    hour_reg;
    logic [dtp_pkg::MINUTE_W-1:0]  minute_reg;
    logic [dtp_pkg::ACC_W-1:0]     mdays;
    logic                          ok;
    logic                          long_month;
    logic                          out_zero;
    logic                          out_in_range;

    always_comb begin
        long_month = (rec.month[0] && (rec.month < dtp_pkg::MONTH_AUG))
                     || (!rec.month[0] && (rec.month >= dtp_pkg::MONTH_AUG));
        if (rec.month == dtp_pkg::MONTH_FEB) begin
            mdays = rec.leap ? dtp_pkg::DAYS_29 : dtp_pkg::DAYS_28;
        end else if (long_month) begin
            mdays = dtp_pkg::DAYS_31;
        end else begin
            mdays = dtp_pkg::DAYS_30;
        end
        ok = rec.fmt_ok
             && (rec.year >= dtp_pkg::YEAR_MIN) && (rec.year <= dtp_pkg::YEAR_MAX)
             && (rec.month != '0) && (rec.month <= dtp_pkg::MONTH_MAX)
             && (rec.day != '0) && (rec.day <= mdays)
             && (rec.hour <= dtp_pkg::HOUR_MAX)
             && (rec.minute <= dtp_pkg::MINUTE_MAX);
    end

    assign pop = !stat.empty && (!m_valid_reg || m_ready);

    always_comb begin
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_ok_reg <= ok;
            year_reg   <= ok ? rec.year : '0;
            month_reg  <= ok ? rec.month[dtp_pkg::MONTH_W-1:0] : '0;
            day_reg    <= ok ? rec.day[dtp_pkg::DAY_W-1:0] : '0;
            hour_reg   <= ok ? rec.hour[dtp_pkg::HOUR_W-1:0] : '0;
            minute_reg <= ok ? rec.minute[dtp_pkg::MINUTE_W-1:0] : '0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign valid_res  = res_ok_reg;
    assign year_out   = year_reg;
    assign month_out  = month_reg;
    assign day_out    = day_reg;
    assign hour_out   = hour_reg;
    assign minute_out = minute_reg;

    assign out_zero     = (year_reg == '0) && (month_reg == '0) && (day_reg == '0)
                          && (hour_reg == '0) && (minute_reg == '0);
    assign out_in_range = (month_reg != '0) && (day_reg != '0)
                          && (year_reg >= dtp_pkg::YEAR_MIN);

    `DTP_ASSERT_NOW(a_no_pop_while_held, aclk, aresetn, !(m_valid_reg && !m_ready && pop))
    `DTP_ASSERT_NEXT(a_pop_loads_output, aclk, aresetn, pop, m_valid_reg)
    `DTP_ASSERT_NOW(a_invalid_is_zero, aclk, aresetn, !(m_valid_reg && !res_ok_reg) || out_zero)
    `DTP_ASSERT_NOW(a_valid_in_range, aclk, aresetn, !(m_valid_reg && res_ok_reg) || out_in_range)

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for datetime_string_parse_validate_unit: sends date-time strings
// as character beats and checks every result against a cycle-free predictor of the parser.
// Depends on dtp_pkg and the RTL of the unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_BEATS  = 1950;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic                         valid;
        logic [dtp_pkg::YEAR_W-1:0]   year;
        logic [dtp_pkg::MONTH_W-1:0]  month;
        logic [dtp_pkg::DAY_W-1:0]    day;
        logic [dtp_pkg::HOUR_W-1:0]   hour;
        logic [dtp_pkg::MINUTE_W-1:0] minute;
    } stamp_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;

    stamp_t            stamp_q[$];
    logic [7:0]        line_buf[$];

    logic [dtp_pkg::POS_W-1:0]  parse_pos;
    logic                       parse_fmt_ok;
    logic [dtp_pkg::YEAR_W-1:0] year_sum;
    logic [dtp_pkg::ACC_W-1:0]  month_sum;
    logic [dtp_pkg::ACC_W-1:0]  day_sum;
    logic [dtp_pkg::ACC_W-1:0]  hour_sum;
    logic [dtp_pkg::ACC_W-1:0]  minute_sum;

    int beats_sent;
    int mismatches;
    int quiet_cycles = 0;
    int gap_max;
    int burst_left;
    int stall_level;
    int stall_tick = 0;
    logic [15:0] stall_mask = '0;

    datetime_string_parse_validate_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        if (m == dtp_pkg::MONTH_FEB) begin
            return is_leap(y) ? dtp_pkg::DAYS_29 : dtp_pkg::DAYS_28;
        end
        if (((m % 2 == 1) && (m < dtp_pkg::MONTH_AUG))
            || ((m % 2 == 0) && (m >= dtp_pkg::MONTH_AUG))) begin
            return dtp_pkg::DAYS_31;
        end
        return dtp_pkg::DAYS_30;
    endfunction

    task automatic clear_parser();
        parse_pos    = '0;
        parse_fmt_ok = 1'b1;
        year_sum     = '0;
        month_sum    = '0;
        day_sum      = '0;
        hour_sum     = '0;
        minute_sum   = '0;
    endtask

    task automatic parse_char(input logic [7:0] ch, input logic last);
        logic        is_num;
        logic        ok;
        int unsigned d;
        int unsigned p;
        stamp_t      res;
        p      = parse_pos;
        is_num = (ch >= dtp_pkg::CH_ZERO) && (ch <= dtp_pkg::CH_NINE);
        d      = is_num ? int'(ch - dtp_pkg::CH_ZERO) : 0;
        if (p >= dtp_pkg::STR_LEN) begin
            parse_fmt_ok = 1'b0;
        end else if (p == dtp_pkg::POS_DASH_A || p == dtp_pkg::POS_DASH_B) begin
            if (ch != dtp_pkg::CH_DASH) parse_fmt_ok = 1'b0;
        end else if (p == dtp_pkg::POS_SLASH) begin
            if (ch != dtp_pkg::CH_SLASH) parse_fmt_ok = 1'b0;
        end else if (p == dtp_pkg::POS_COLON) begin
            if (ch != dtp_pkg::CH_COLON) parse_fmt_ok = 1'b0;
        end else if (!is_num) begin
            parse_fmt_ok = 1'b0;
        end else if (p < dtp_pkg::POS_DASH_A) begin
            year_sum = dtp_pkg::YEAR_W'(year_sum * 10 + d);
        end else if (p < dtp_pkg::POS_DASH_B) begin
            month_sum = dtp_pkg::ACC_W'(month_sum * 10 + d);
        end else if (p < dtp_pkg::POS_SLASH) begin
            day_sum = dtp_pkg::ACC_W'(day_sum * 10 + d);
        end else if (p < dtp_pkg::POS_COLON) begin
            hour_sum = dtp_pkg::ACC_W'(hour_sum * 10 + d);
        end else begin
            minute_sum = dtp_pkg::ACC_W'(minute_sum * 10 + d);
        end
        parse_pos = (p < dtp_pkg::POS_SAT) ? dtp_pkg::POS_W'(p + 1) : dtp_pkg::POS_SAT;
        if (last) begin
            ok = parse_fmt_ok && (parse_pos == dtp_pkg::STR_LEN);
            if (year_sum < dtp_pkg::YEAR_MIN || year_sum > dtp_pkg::YEAR_MAX) ok = 1'b0;
            if (month_sum < 1 || month_sum > dtp_pkg::MONTH_MAX) ok = 1'b0;
            if (ok && (day_sum < 1 || day_sum > month_length(year_sum, month_sum))) ok = 1'b0;
            if (hour_sum > dtp_pkg::HOUR_MAX || minute_sum > dtp_pkg::MINUTE_MAX) ok = 1'b0;
            res = '0;
            if (ok) begin
                res.valid  = 1'b1;
                res.year   = year_sum;
                res.month  = month_sum[dtp_pkg::MONTH_W-1:0];
                res.day    = day_sum[dtp_pkg::DAY_W-1:0];
                res.hour   = hour_sum[dtp_pkg::HOUR_W-1:0];
                res.minute = minute_sum[dtp_pkg::MINUTE_W-1:0];
            end
            stamp_q.push_back(res);
            clear_parser();
        end
    endtask

    task automatic put_digits(input int unsigned value, input int n);
        int unsigned div;
        div = 1;
        repeat (n - 1) div = div * 10;
        repeat (n) begin
            line_buf.push_back(8'(dtp_pkg::CH_ZERO + (value / div) % 10));
            div = div / 10;
        end
    endtask

    task automatic build_stamp(input int unsigned y, input int unsigned mo, input int unsigned d,
                               input int unsigned h, input int unsigned mi);
        line_buf.delete();
        put_digits(y, 4);
        line_buf.push_back(dtp_pkg::CH_DASH);
        put_digits(mo, 2);
        line_buf.push_back(dtp_pkg::CH_DASH);
        put_digits(d, 2);
        line_buf.push_back(dtp_pkg::CH_SLASH);
        put_digits(h, 2);
        line_buf.push_back(dtp_pkg::CH_COLON);
        put_digits(mi, 2);
    endtask

    // Called at a falling edge; returns at the falling edge after the last beat was taken.
    task automatic send_line();
        int gap;
        for (int i = 0; i < line_buf.size(); i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            burst_left--;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= line_buf[i];
            s_axis_tlast  <= (i == line_buf.size() - 1);
            do @(posedge aclk); while (!s_axis_tready);
            parse_char(line_buf[i], i == line_buf.size() - 1);
            beats_sent++;
            @(negedge aclk);
        end
    endtask

    task automatic pick_idling();
        case ($urandom_range(0, 3))
            0: gap_max = 0;
            1: gap_max = 1;
            2: gap_max = 3;
            default: gap_max = 8;
        endcase
        stall_level = $urandom_range(0, 2);
    endtask

    task automatic test_calendar_extremes();
        gap_max     = 0;
        stall_level = 0;
        build_stamp(1000, 1, 1, 0, 0);    send_line();
        build_stamp(9999, 12, 31, 23, 59); send_line();
        build_stamp(2000, 2, 29, 12, 30); send_line();
        build_stamp(1900, 2, 29, 6, 15);  send_line();
        build_stamp(2024, 2, 29, 1, 1);   send_line();
        build_stamp(2023, 2, 29, 1, 1);   send_line();
        build_stamp(2023, 2, 28, 1, 1);   send_line();
        build_stamp(2023, 4, 31, 9, 9);   send_line();
        build_stamp(2023, 8, 31, 9, 9);   send_line();
        build_stamp(999, 5, 5, 5, 5);     send_line();
        build_stamp(2023, 13, 1, 0, 0);   send_line();
        build_stamp(2023, 0, 10, 0, 0);   send_line();
        build_stamp(2023, 5, 0, 0, 0);    send_line();
        build_stamp(2023, 5, 10, 24, 0);  send_line();
        build_stamp(2023, 5, 10, 23, 60); send_line();
    endtask

    task automatic test_format_faults();
        pick_idling();
        build_stamp(2024, 6, 15, 8, 45); line_buf[4] = dtp_pkg::CH_SLASH;  send_line();
        build_stamp(2024, 6, 15, 8, 45); line_buf[7] = dtp_pkg::CH_COLON;  send_line();
        build_stamp(2024, 6, 15, 8, 45); line_buf[10] = dtp_pkg::CH_DASH;  send_line();
        build_stamp(2024, 6, 15, 8, 45); line_buf[13] = dtp_pkg::CH_SLASH; send_line();
        build_stamp(2024, 6, 15, 8, 45); line_buf[15] = 8'h61;             send_line();
        build_stamp(2024, 6, 15, 8, 45); line_buf[14] = 8'h00;             send_line();
        build_stamp(2024, 6, 15, 8, 45); line_buf[0] = 8'hFF;              send_line();
        build_stamp(2024, 6, 15, 8, 45); line_buf[5] = dtp_pkg::CH_COLON;  send_line();
        build_stamp(2024, 6, 15, 8, 45); line_buf[9] = dtp_pkg::CH_SLASH;  send_line();
        build_stamp(2024, 6, 15, 8, 45); void'(line_buf.pop_back());       send_line();
        line_buf.delete(); line_buf.push_back(dtp_pkg::CH_ZERO + 8'd2);    send_line();
        build_stamp(2024, 6, 15, 8, 45); line_buf.push_back(dtp_pkg::CH_ZERO); send_line();
        build_stamp(2024, 6, 15, 8, 45);
        repeat (6) line_buf.push_back(dtp_pkg::CH_NINE);
        send_line();
    endtask

    task automatic test_random_stamps();
        int unsigned y, mo, d, h, mi;
        int kind;
        int cut;
        int n;
        n = 0;
        while (beats_sent < TOTAL_BEATS) begin
            if (n % 16 == 0) pick_idling();
            n++;
            case ($urandom_range(0, 9))
                0: y = $urandom_range(0, 9999);
                1: y = $urandom_range(10, 99) * 100;
                2: y = $urandom_range(250, 2499) * 4;
                default: y = $urandom_range(1000, 9999);
            endcase
            mo = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0) mo = dtp_pkg::MONTH_FEB;
            case ($urandom_range(0, 9))
                0: d = $urandom_range(0, 99);
                1, 2: d = $urandom_range(28, 31);
                default: d = $urandom_range(1, 31);
            endcase
            h  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 23) : $urandom_range(0, 99);
            mi = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 59) : $urandom_range(0, 99);
            build_stamp(y, mo, d, h, mi);
            kind = $urandom_range(0, 99);
            if (kind >= 94) begin
                line_buf.delete();
                repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
            end else if (kind >= 88) begin
                repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
            end else if (kind >= 80) begin
                cut = $urandom_range(1, 15);
                while (line_buf.size() > cut) void'(line_buf.pop_back());
            end else if (kind >= 65) begin
                line_buf[$urandom_range(0, 15)] = 8'($urandom_range(0, 255));
            end
            send_line();
        end
    endtask

    always @(negedge aclk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick[4:0] == 5'd0) begin
            case (stall_level)
                0: stall_mask <= '0;
                1: stall_mask <= 16'($urandom & $urandom) & 16'hFFFE;
                default: stall_mask <= 16'($urandom) & 16'hFFFE;
            endcase
        end
        m_axis_tready <= !stall_mask[stall_tick[3:0]];
    end

    always @(posedge aclk) begin : check_results
        stamp_t got;
        stamp_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.valid  = m_axis_tuser;
            got.year   = m_axis_tdata[13:0];
            got.month  = m_axis_tdata[17:14];
            got.day    = m_axis_tdata[22:18];
            got.hour   = m_axis_tdata[27:23];
            got.minute = m_axis_tdata[33:28];
            if (stamp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("Unexpected result beat: valid=%0d %0d-%0d-%0d %0d:%0d",
                             got.valid, got.year, got.month, got.day, got.hour, got.minute);
                end
            end else begin
                want = stamp_q.pop_front();
                if (got.valid != want.valid || got.year != want.year ||
                    got.month != want.month || got.day != want.day ||
                    got.hour != want.hour || got.minute != want.minute) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("Result mismatch: expected valid=%0d %0d-%0d-%0d %0d:%0d",
                                 want.valid, want.year, want.month, want.day, want.hour,
                                 want.minute);
                        $display("                 got      valid=%0d %0d-%0d-%0d %0d:%0d",
                                 got.valid, got.year, got.month, got.day, got.hour,
                                 got.minute);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** datetime_string_parse_validate_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        stall_level   = 0;
        gap_max       = 0;
        burst_left    = 0;
        beats_sent    = 0;
        mismatches    = 0;
        clear_parser();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_calendar_extremes();
        test_format_faults();
        test_random_stamps();

        s_axis_tvalid <= 1'b0;
        while (stamp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && stamp_q.size() == 0) begin
            $display("** datetime_string_parse_validate_unit: PASSED **");
        end else begin
            $display("** datetime_string_parse_validate_unit: FAILED **");
        end
        $finish;
    end

endmodule
